// ===== rtl/sorted_table_key_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table key lookup
// Implication checks on the rising clock edge; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_KEY_LOOKUP_ASSERT_SVH
`define SORTED_TABLE_KEY_LOOKUP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define STKL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stkl assertion failed");
// next-cycle implication
`define STKL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stkl assertion failed");
`else
`define STKL_ASSERT_IMP(label, clk, rst, ante, cons)
`define STKL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/stkl_pkg.sv =====
// ----------------------------------------------------------------------------
// stkl_pkg
// Widths, op codes and register indexes of the sorted table key lookup.
// ----------------------------------------------------------------------------
package stkl_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;

   localparam int SLOT_W      = 10;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 11;
   localparam int ENTRY_W     = KEY_W + VALUE_W;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // request kind carried on req_tuser
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // register index, taken from csr_paddr[2]
   localparam logic REG_ENTRY_COUNT = 1'b0;

endpackage

// ===== rtl/stkl_ram.sv =====
// ----------------------------------------------------------------------------
// stkl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stkl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sorted_table_key_lookup.sv =====
// ----------------------------------------------------------------------------
// sorted_table_key_lookup
// Key/value table in one RAM, searched by a bounded binary search.
// ----------------------------------------------------------------------------
// A write transfer (req_tuser = 0) stores one key/value pair at its slot and
// returns no result; slots at or above TABLE_DEPTH are dropped without a write.
// A lookup transfer (req_tuser = 1) searches slots 0 .. entry_count-1 (count
// clipped to TABLE_DEPTH) and returns one transfer with rsp_tuser = found and
// rsp_tdata = the value, or 0 on a miss. The table RAM is not cleared after
// reset: load the slots in ascending key order and set entry_count through
// the register port before searching. One entry is probed per cycle, limited
// by the single RAM read port with its registered read data, so a lookup
// holds the input until its search ends, which comes sooner when a probe hits
// early. An empty table skips the RAM and goes straight to the done state. A
// finished result waits in the output register while new writes and the next
// lookup's search go ahead; a lookup that finishes while that register is
// still occupied holds the input until the waiting result is taken.
// ----------------------------------------------------------------------------
`include "sorted_table_key_lookup_assert.svh"

module sorted_table_key_lookup
   import stkl_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // slot[9:0], key[41:10], value[73:42]
   input  logic                   req_tuser,   // op
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // result_value[31:0]
   output logic                   rsp_tuser,   // found
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               res_found_ff, res_found_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [SLOT_W-1:0]  req_slot;
   logic [KEY_W-1:0]   req_key;
   logic [VALUE_W-1:0] req_value;
   logic               req_xfer;
   logic               slot_ok;
   logic               csr_wr;

   logic [CMP_W-1:0]   count_wide;
   logic [CMP_W-1:0]   depth_wide;
   logic [CNT_W-1:0]   count_sat;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [KEY_W-1:0]   probe_key;
   logic [VALUE_W-1:0] probe_value;

   logic [CNT_W-1:0]   next_lo;
   logic [CNT_W-1:0]   next_hi;
   logic [CNT_W-1:0]   probe_lo;
   logic [CNT_W-1:0]   probe_hi;
   logic [SUM_W-1:0]   probe_sum;
   logic [CNT_W-1:0]   probe_mid;
   logic               out_free;

   assign req_slot  = req_tdata[SLOT_W-1:0];
   assign req_key   = req_tdata[SLOT_W+KEY_W-1:SLOT_W];
   assign req_value = req_tdata[SLOT_W+KEY_W+VALUE_W-1:SLOT_W+KEY_W];
   assign req_xfer  = req_tvalid && req_tready;
   assign slot_ok   = (32'(req_slot) < 32'(TABLE_DEPTH));

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign count_in   = (csr_wr && csr_paddr[2] == REG_ENTRY_COUNT)
                       ? csr_pwdata[COUNT_W-1:0] : count_ff;
   assign csr_prdata = (csr_paddr[2] == REG_ENTRY_COUNT)
                       ? CSR_DATA_W'(count_ff) : '0;

   assign count_wide = CMP_W'(count_ff);
   assign depth_wide = CMP_W'(TABLE_DEPTH);
   assign count_sat  = (count_wide > depth_wide) ? CNT_W'(depth_wide)
                                                 : CNT_W'(count_wide);

   stkl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_slot)),
      .wr_data ({req_value, req_key}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign probe_key   = ram_rd_data[KEY_W-1:0];
   assign probe_value = ram_rd_data[ENTRY_W-1:KEY_W];

   // narrow the window around the entry that just came back
   assign next_lo = (key_ff > probe_key) ? mid_ff + 1'b1 : lo_ff;
   assign next_hi = (key_ff < probe_key) ? mid_ff : hi_ff;

   assign probe_lo    = (state_ff == ST_SEARCH) ? next_lo : '0;
   assign probe_hi    = (state_ff == ST_SEARCH) ? next_hi : count_sat;
   assign probe_sum   = SUM_W'(probe_lo) + SUM_W'(probe_hi);
   assign probe_mid   = probe_sum[SUM_W-1:1];
   assign ram_rd_addr = probe_mid[ADDR_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_value_in = res_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               if (req_tuser == OP_WRITE) begin
                  ram_wr_en = slot_ok;
               end else begin
                  key_in = req_key;
                  if (count_sat != '0) begin
                     ram_rd_en = 1'b1;
                     lo_in     = '0;
                     hi_in     = count_sat;
                     mid_in    = probe_mid;
                     state_in  = ST_SEARCH;
                  end else begin
                     res_found_in = 1'b0;
                     res_value_in = '0;
                     state_in     = ST_DONE;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (key_ff == probe_key || next_lo >= next_hi) begin
               // hit, or window closed on a miss
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = (key_ff == probe_key);
                  rsp_value_in = (key_ff == probe_key) ? probe_value : '0;
                  state_in     = ST_IDLE;
               end else begin
                  res_found_in = (key_ff == probe_key);
                  res_value_in = (key_ff == probe_key) ? probe_value : '0;
                  state_in     = ST_DONE;
               end
            end else begin
               ram_rd_en = 1'b1;
               lo_in     = next_lo;
               hi_in     = next_hi;
               mid_in    = probe_mid;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_value_in = res_value_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_value_ff <= res_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_value_ff;

   `STKL_ASSERT_IMP(a_search_window, clock, reset, state_ff == ST_SEARCH,
      lo_ff < hi_ff && mid_ff >= lo_ff && mid_ff < hi_ff)
   `STKL_ASSERT_IMP(a_write_only_idle, clock, reset, ram_wr_en, state_ff == ST_IDLE && !ram_rd_en)
   `STKL_ASSERT_IMP(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
      rsp_value_ff == '0)
   `STKL_ASSERT_NXT(a_lookup_starts, clock, reset,
      req_xfer && req_tuser == OP_LOOKUP && count_sat != '0, state_ff == ST_SEARCH)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted key/value table with binary search.
// Loads the table in key order over the request stream, sets entry_count over
// the register port between phases and checks every lookup transfer against
// a fixed expected result or an in-bench search of a shadow copy of the table.
// ----------------------------------------------------------------------------
module testbench;
   import stkl_pkg::*;

   localparam int TABLE_DEPTH   = TABLE_DEPTH_DEFAULT;
   localparam int IDLE_PCT      = 10;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 24;
   localparam int QUIET_LIMIT   = 2000;
   localparam int KEY_STEP_MAX  = 7000000;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] value;
   } lookup_result_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_COUNT} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic               op;
      logic [SLOT_W-1:0]  slot;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               pinned;
      lookup_result_type  known;
   } row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;   // slot[9:0], key[41:10], value[73:42]
   logic                   req_tuser   = 1'b0; // op
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // result_value[31:0]
   logic                   rsp_tuser;          // found
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // shadow table and register
   logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
   logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];
   logic [COUNT_W-1:0] table_count = '0;

   lookup_result_type answer_q [$];
   row_type           plan [$];

   bit             steady = 1'b0;
   int unsigned    loaded;
   logic [KEY_W-1:0] next_key;
   int unsigned    error_count  = 0;
   int unsigned    writes_sent  = 0;
   int unsigned    lookups_sent = 0;
   int unsigned    hits_sent    = 0;
   int unsigned    count_writes = 0;
   int unsigned    quiet_cycles = 0;

   sorted_table_key_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

   // bounded binary search over the shadow table, count clipped to the depth
   function automatic lookup_result_type search_table(input logic [KEY_W-1:0] probe);
      lookup_result_type res;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      res = '0;
      lo  = 0;
      hi  = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (probe < key_mem[mid]) begin
            hi = mid;
         end else if (probe > key_mem[mid]) begin
            lo = mid + 1;
         end else begin
            res.found = 1'b1;
            res.value = value_mem[mid];
            break;
         end
      end
      return res;
   endfunction

   function automatic row_type row_store(input logic [SLOT_W-1:0] slot,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] value);
      return '{ROW_ITEM, OP_WRITE, slot, key, value, 1'b0, '0};
   endfunction

   function automatic row_type row_probe(input logic [KEY_W-1:0] key);
      return '{ROW_ITEM, OP_LOOKUP, '0, key, '0, 1'b0, '0};
   endfunction

   function automatic row_type row_pinned(input logic [KEY_W-1:0] key, input logic found,
                                          input logic [VALUE_W-1:0] value);
      return '{ROW_ITEM, OP_LOOKUP, '0, key, '0, 1'b1, '{found, value}};
   endfunction

   function automatic row_type row_count(input logic [COUNT_W-1:0] count);
      return '{ROW_COUNT, OP_WRITE, '0, '0, VALUE_W'(count), 1'b0, '0};
   endfunction

   task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                               input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value,
                               input logic pinned, input lookup_result_type known);
      lookup_result_type answer;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({value, key, slot});
      do @(posedge clock); while (req_tready !== 1'b1);
      if (op == OP_WRITE) begin
         key_mem[slot]   = key;
         value_mem[slot] = value;
         writes_sent++;
      end else begin
         answer = pinned ? known : search_table(key);
         answer_q.push_back(answer);
         lookups_sent++;
         if (answer.found) hits_sent++;
      end
   endtask

   // drain all lookups, then write entry_count and read it back
   task automatic set_entry_count(input logic [COUNT_W-1:0] count);
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      table_count = count;
      count_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_W'(count)) begin
         $display("%0t: entry_count readback mismatch, expected %0d, got %0d",
                  $time, count, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // extend the sorted prefix; a few steps of zero give duplicate keys
   task automatic grow_table(input int unsigned grow);
      logic [KEY_W:0] sum;
      repeat (grow) begin
         send_request(OP_WRITE, SLOT_W'(loaded), next_key, $urandom(), 1'b0, '0);
         loaded++;
         sum = {1'b0, next_key} +
               (($urandom_range(0, 15) == 0) ? '0 : (KEY_W + 1)'($urandom_range(1, KEY_STEP_MAX)));
         next_key = sum[KEY_W] ? '1 : sum[KEY_W-1:0];
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_probe_key();
      int unsigned      span;
      logic [KEY_W-1:0] k;
      span = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
      k    = $urandom();
      case ($urandom_range(0, 19))
         0: k = '0;
         1: k = '1;
         2, 3, 4: k = $urandom();
         5, 6, 7: begin
            if (span != 0)
               k = key_mem[$urandom_range(0, span - 1)] +
                   ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
         end
         default: begin
            if (span != 0) k = key_mem[$urandom_range(0, span - 1)];
         end
      endcase
      return k;
   endfunction

   // mostly lookups; some writes update a value in place, some break the order
   task automatic probe_phase(input int unsigned n);
      int unsigned s;
      repeat (n) begin
         if ($urandom_range(0, 99) < 10) begin
            s = $urandom_range(0, loaded - 1);
            send_request(OP_WRITE, SLOT_W'(s),
                         $urandom_range(0, 1) ? key_mem[s] : KEY_W'($urandom()),
                         $urandom(), 1'b0, '0);
         end else begin
            send_request(OP_LOOKUP, SLOT_W'($urandom()), pick_probe_key(), $urandom(),
                         1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected result transfer, found %0b value %08h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found mismatch, expected %0b, got %0b",
                        $time, want.found, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== want.value) begin
               $display("%0t: value mismatch, expected %08h, got %08h",
                        $time, want.value, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, answer_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned grow;
      logic [COUNT_W-1:0] count;

      plan = '{
         row_pinned(32'h0000_0000, 1'b0, 32'h0),          // empty table
         row_pinned(32'hFFFF_FFFF, 1'b0, 32'h0),
         row_store(10'd0, 32'h0000_0000, 32'hFFFF_FFFF),
         row_store(10'd1, 32'h0000_0005, 32'h0000_0000),
         row_store(10'd2, 32'h0000_0064, 32'h0000_04D2),
         row_store(10'd3, 32'h0000_0064, 32'h0000_0309),  // duplicate key
         row_store(10'd4, 32'h8000_0000, 32'hA5A5_A5A5),
         row_store(10'd5, 32'hFFFF_FFFE, 32'h0000_0001),
         row_store(10'd6, 32'hFFFF_FFFF, 32'h5A5A_5A5A),
         row_store(10'd1023, 32'h1234_5678, 32'h8765_4321),
         row_count(11'd7),
         row_pinned(32'h0000_0000, 1'b1, 32'hFFFF_FFFF),
         row_pinned(32'hFFFF_FFFF, 1'b1, 32'h5A5A_5A5A),
         row_pinned(32'h0000_0005, 1'b1, 32'h0000_0000),
         row_pinned(32'h0000_0003, 1'b0, 32'h0),
         row_probe(32'h0000_0064),
         row_pinned(32'h8000_0000, 1'b1, 32'hA5A5_A5A5),
         row_pinned(32'h7FFF_FFFF, 1'b0, 32'h0),
         row_pinned(32'hFFFF_FFFE, 1'b1, 32'h0000_0001),
         row_count(11'd0),
         row_pinned(32'h0000_0000, 1'b0, 32'h0),          // empty again, table loaded
         row_count(11'd1),
         row_pinned(32'h0000_0005, 1'b0, 32'h0),
         row_pinned(32'h0000_0000, 1'b1, 32'hFFFF_FFFF),
         row_store(10'd2, 32'h0000_0003, 32'h0000_002A),  // out of order
         row_count(11'd7),
         row_probe(32'h0000_0003)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_COUNT)
            set_entry_count(plan[i].value[COUNT_W-1:0]);
         else
            send_request(plan[i].op, plan[i].slot, plan[i].key, plan[i].value,
                         plan[i].pinned, plan[i].known);
      end

      // rebuild the table from slot 0 in key order, searching between loads
      loaded   = 0;
      next_key = $urandom_range(0, 1000);
      phase    = 0;
      while (loaded < TABLE_DEPTH) begin
         steady <= (phase == 2 || phase == 3);
         grow = $urandom_range(40, 110);
         if (grow > TABLE_DEPTH - loaded) grow = TABLE_DEPTH - loaded;
         grow_table(grow);
         case ($urandom_range(0, 5))
            0: count = COUNT_W'($urandom_range(0, 2));
            1, 2: count = COUNT_W'(loaded);
            default: count = COUNT_W'($urandom_range(0, loaded));
         endcase
         set_entry_count(count);
         probe_phase($urandom_range(6, 14));
         phase++;
      end
      steady <= 1'b0;

      // full table, then counts past the depth that the search must clip
      set_entry_count(COUNT_W'(TABLE_DEPTH));
      probe_phase(12);
      set_entry_count('1);
      probe_phase(12);
      set_entry_count(COUNT_W'($urandom_range(TABLE_DEPTH + 1, 2046)));
      probe_phase(12);
      set_entry_count(COUNT_W'($urandom_range(0, TABLE_DEPTH)));
      probe_phase(12);

      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d table writes and %0d lookups (%0d predicted hits)",
               writes_sent, lookups_sent, hits_sent);
      $display("over %0d entry_count settings, including empty, full and clipped.",
               count_writes);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
